[sv/owbm_pkg.sv]
// package for the one-wire bus master core
// holds item types, operation codes, register indexes, reset values and the delay loader
// no dependencies
package owbm_pkg;

  localparam int COUNT_BITS = 10;
  localparam int CFG_WIDTH  = 10;
  localparam int IDX_WIDTH  = 3;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;
  localparam logic [1:0] OP_CMD   = 2'd3;

  localparam logic [IDX_WIDTH-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_SLOT_LOW      = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_SLOT_END      = 3'd4;

  localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd480;
  localparam logic [9:0] PRESENCE_WAIT_DEFAULT = 10'd72;
  localparam logic [9:0] RESET_TAIL_DEFAULT    = 10'd428;
  localparam logic [7:0] SLOT_LOW_DEFAULT      = 8'd2;
  localparam logic [7:0] SLOT_END_DEFAULT      = 8'd45;

  localparam logic [7:0] SKIP_ROM_BYTE = 8'hCC;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [1:0] STAGE_NONE = 2'd0;
  localparam logic [1:0] STAGE_RST  = 2'd1;
  localparam logic [1:0] STAGE_SKIP = 2'd2;
  localparam logic [1:0] STAGE_CMD  = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       bus_error;
  } out_item_t;

  // saturate to the counter range, zero counts as one microsecond
  function automatic logic [COUNT_BITS-1:0] load_delay(input logic [9:0] v);
    logic [COUNT_BITS-1:0] r;
    if (COUNT_BITS < 10 && v > 10'(COUNT_MAX)) begin
      r = COUNT_MAX;
    end else begin
      r = COUNT_BITS'(v);
    end
    if (r == '0) begin
      r = COUNT_BITS'(1);
    end
    return r;
  endfunction

endpackage

[sv/owbm_if.sv]
// valid/ready channel interfaces for the one-wire bus master core
// depends on owbm_pkg for the item types
interface owbm_in_if;
  logic               valid;
  logic               ready;
  owbm_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface owbm_out_if;
  logic                valid;
  logic                ready;
  owbm_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/one_wire_bus_master_core.sv]
// one-wire bus master core: reset, byte transfer and skip-rom command sequencer
// depends on owbm_pkg and the channel interfaces in owbm_if.sv
//
// usage: every item on in_ch is either a one-microsecond tick carrying the sampled
// line level, or a start of a reset, a byte transfer or a command (reset, skip rom,
// command byte). each accepted item yields exactly one result on out_ch with the
// line drive state, busy, done, the last read-back byte and the bus error flag.
// the state update and result are registered when an item is accepted and the result
// is valid in the next cycle. throughput is one item per cycle while out_ch takes every
// result; when out_ch stalls, the result register holds and in_ch.ready drops until the
// result is taken; a new item is accepted in the same cycle the old result leaves.
// the cfg port writes the delay registers; it is meant for use while idle.
// synchronous reset returns to idle with the line released, clears the status and
// loads the default timing (480/72/428/2/45 us).
module one_wire_bus_master_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [owbm_pkg::IDX_WIDTH-1:0]       cfg_index,
  input  logic [owbm_pkg::CFG_WIDTH-1:0]       cfg_data,
  owbm_in_if.sink                              in_ch,
  owbm_out_if.source                           out_ch
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_TAIL,
    PH_SLOT_LOW,
    PH_SLOT_SAMPLE,
    PH_SLOT_END
  } phase_t;

  localparam int CB = owbm_pkg::COUNT_BITS;

  logic [9:0] reset_low_us, presence_wait_us, reset_tail_us;
  logic [7:0] slot_low_us, slot_end_us;

  phase_t          phase, phase_next;
  logic [CB-1:0]   us_countdown, us_countdown_next;
  logic [7:0]      shift_byte, shift_byte_next;
  logic [3:0]      bits_left, bits_left_next;
  logic [7:0]      pending_cmd, pending_cmd_next;
  logic [1:0]      cmd_stage, cmd_stage_next;
  logic            error_flag, error_flag_next;
  logic            line_driven, line_driven_next;
  logic [7:0]      last_read, last_read_next;
  logic            done;
  logic            expired;
  logic [CB-1:0]   count_dec;
  logic            out_valid;
  owbm_pkg::out_item_t out_item;
  logic            accept;

  owbm_pkg::in_item_t item;
  assign item = in_ch.payload;

  assign in_ch.ready    = !out_valid || out_ch.ready;
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_us     <= owbm_pkg::RESET_LOW_DEFAULT;
      presence_wait_us <= owbm_pkg::PRESENCE_WAIT_DEFAULT;
      reset_tail_us    <= owbm_pkg::RESET_TAIL_DEFAULT;
      slot_low_us      <= owbm_pkg::SLOT_LOW_DEFAULT;
      slot_end_us      <= owbm_pkg::SLOT_END_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owbm_pkg::REG_RESET_LOW:     reset_low_us     <= cfg_data[9:0];
        owbm_pkg::REG_PRESENCE_WAIT: presence_wait_us <= cfg_data[9:0];
        owbm_pkg::REG_RESET_TAIL:    reset_tail_us    <= cfg_data[9:0];
        owbm_pkg::REG_SLOT_LOW:      slot_low_us      <= cfg_data[7:0];
        owbm_pkg::REG_SLOT_END:      slot_end_us      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign count_dec = us_countdown - CB'(1);
  assign expired   = (count_dec == '0);

  always_comb begin
    phase_next        = phase;
    us_countdown_next = us_countdown;
    shift_byte_next   = shift_byte;
    bits_left_next    = bits_left;
    pending_cmd_next  = pending_cmd;
    cmd_stage_next    = cmd_stage;
    error_flag_next   = error_flag;
    line_driven_next  = line_driven;
    last_read_next    = last_read;
    done              = 1'b0;

    if (item.operation != owbm_pkg::OP_TICK) begin
      if (phase == PH_IDLE) begin
        line_driven_next = 1'b1;
        unique case (item.operation)
          owbm_pkg::OP_BYTE: begin
            cmd_stage_next    = owbm_pkg::STAGE_NONE;
            shift_byte_next   = item.data_byte;
            bits_left_next    = owbm_pkg::BITS_PER_BYTE;
            phase_next        = PH_SLOT_LOW;
            us_countdown_next = owbm_pkg::load_delay({2'b00, slot_low_us});
          end
          owbm_pkg::OP_CMD: begin
            pending_cmd_next  = item.data_byte;
            cmd_stage_next    = owbm_pkg::STAGE_RST;
            phase_next        = PH_RST_LOW;
            us_countdown_next = owbm_pkg::load_delay(reset_low_us);
          end
          default: begin
            cmd_stage_next    = owbm_pkg::STAGE_NONE;
            phase_next        = PH_RST_LOW;
            us_countdown_next = owbm_pkg::load_delay(reset_low_us);
          end
        endcase
      end
    end else if (phase != PH_IDLE) begin
      if (phase != PH_SLOT_SAMPLE) begin
        us_countdown_next = count_dec;
      end
      unique case (phase)
        PH_RST_LOW: begin
          if (expired) begin
            line_driven_next  = 1'b0;
            phase_next        = PH_RST_WAIT;
            us_countdown_next = owbm_pkg::load_delay(presence_wait_us);
          end
        end
        PH_RST_WAIT: begin
          if (expired) begin
            error_flag_next   = item.line_level;
            phase_next        = PH_RST_TAIL;
            us_countdown_next = owbm_pkg::load_delay(reset_tail_us);
          end
        end
        PH_RST_TAIL: begin
          if (expired) begin
            if (!item.line_level) begin
              error_flag_next = 1'b1;
            end
            if (cmd_stage == owbm_pkg::STAGE_RST) begin
              cmd_stage_next    = owbm_pkg::STAGE_SKIP;
              shift_byte_next   = owbm_pkg::SKIP_ROM_BYTE;
              bits_left_next    = owbm_pkg::BITS_PER_BYTE;
              line_driven_next  = 1'b1;
              phase_next        = PH_SLOT_LOW;
              us_countdown_next = owbm_pkg::load_delay({2'b00, slot_low_us});
            end else begin
              cmd_stage_next = owbm_pkg::STAGE_NONE;
              phase_next     = PH_IDLE;
              done           = 1'b1;
            end
          end
        end
        PH_SLOT_LOW: begin
          if (expired) begin
            if (shift_byte[0]) begin
              line_driven_next = 1'b0;
            end
            phase_next = PH_SLOT_SAMPLE;
          end
        end
        PH_SLOT_SAMPLE: begin
          shift_byte_next   = {shift_byte[0] & item.line_level, shift_byte[7:1]};
          bits_left_next    = bits_left - 4'd1;
          phase_next        = PH_SLOT_END;
          us_countdown_next = owbm_pkg::load_delay({2'b00, slot_end_us});
        end
        PH_SLOT_END: begin
          if (expired) begin
            line_driven_next = 1'b0;
            priority if (bits_left != 4'd0) begin
              line_driven_next  = 1'b1;
              phase_next        = PH_SLOT_LOW;
              us_countdown_next = owbm_pkg::load_delay({2'b00, slot_low_us});
            end else if (cmd_stage == owbm_pkg::STAGE_SKIP) begin
              cmd_stage_next    = owbm_pkg::STAGE_CMD;
              shift_byte_next   = pending_cmd;
              bits_left_next    = owbm_pkg::BITS_PER_BYTE;
              line_driven_next  = 1'b1;
              phase_next        = PH_SLOT_LOW;
              us_countdown_next = owbm_pkg::load_delay({2'b00, slot_low_us});
            end else if (cmd_stage == owbm_pkg::STAGE_CMD) begin
              cmd_stage_next = owbm_pkg::STAGE_NONE;
              phase_next     = PH_IDLE;
              done           = 1'b1;
            end else begin
              last_read_next = shift_byte;
              cmd_stage_next = owbm_pkg::STAGE_NONE;
              phase_next     = PH_IDLE;
              done           = 1'b1;
            end
          end
        end
        default: begin
          phase_next       = PH_IDLE;
          line_driven_next = 1'b0;
          cmd_stage_next   = owbm_pkg::STAGE_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      us_countdown <= '0;
      shift_byte   <= '0;
      bits_left    <= '0;
      pending_cmd  <= '0;
      cmd_stage    <= owbm_pkg::STAGE_NONE;
      error_flag   <= 1'b0;
      line_driven  <= 1'b0;
      last_read    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        us_countdown <= us_countdown_next;
        shift_byte   <= shift_byte_next;
        bits_left    <= bits_left_next;
        pending_cmd  <= pending_cmd_next;
        cmd_stage    <= cmd_stage_next;
        error_flag   <= error_flag_next;
        line_driven  <= line_driven_next;
        last_read    <= last_read_next;
        out_valid    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item.drive_low <= line_driven_next;
      out_item.busy_res  <= (phase_next != PH_IDLE);
      out_item.done_res  <= done;
      out_item.read_byte <= last_read_next;
      out_item.bus_error <= error_flag_next;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transfer produced no result");

  a_drive_only_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.drive_low && !out_item.busy_res))
    else $error("line driven low while idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res)
    else $error("done reported while still busy");

  a_bits_in_range: assert property (@(posedge clk) disable iff (rst)
    bits_left <= owbm_pkg::BITS_PER_BYTE)
    else $error("bit counter out of range");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !line_driven && cmd_stage == owbm_pkg::STAGE_NONE)
    else $error("idle with line driven or command pending");

endmodule

[tb/sv/owbm_bus_checker.sv]
// status checker for the one-wire bus master core: watches the item, result and register ports,
// keeps its own model of the bus sequencer and compares every result transfer field by field
// depends on owbm_pkg and the channel interfaces in owbm_if.sv
module owbm_bus_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [owbm_pkg::IDX_WIDTH-1:0] cfg_index,
  input  logic [owbm_pkg::CFG_WIDTH-1:0] cfg_data,
  owbm_in_if                             in_ch,
  owbm_out_if                            out_ch,
  output int                             fails,
  output int                             expected_left,
  output logic                           model_busy
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HOLD_LOW,
    ST_PRESENCE,
    ST_TAIL,
    ST_SLOT_LOW,
    ST_SLOT_READ,
    ST_SLOT_REST
  } bus_phase_t;

  bus_phase_t                      ph;
  logic [owbm_pkg::COUNT_BITS-1:0] countdown;
  logic [7:0]                      shreg, cmd_byte, rd_byte;
  logic [3:0]                      bits_to_go;
  logic [1:0]                      stage;
  logic                            err, drive;
  logic [9:0]                      t_reset_low, t_presence, t_tail;
  logic [7:0]                      t_slot_low, t_slot_end;
  owbm_pkg::out_item_t             expected_status[$];
  int                              errs = 0;

  function automatic logic [owbm_pkg::COUNT_BITS-1:0] clamp_delay(input logic [9:0] us);
    int unsigned n;
    n = us;
    if (n > (1 << owbm_pkg::COUNT_BITS) - 1) n = (1 << owbm_pkg::COUNT_BITS) - 1;
    if (n == 0) n = 1;
    return owbm_pkg::COUNT_BITS'(n);
  endfunction

  function automatic void start_reset();
    drive = 1'b1;
    ph = ST_HOLD_LOW;
    countdown = clamp_delay(t_reset_low);
  endfunction

  function automatic void start_slot();
    drive = 1'b1;
    ph = ST_SLOT_LOW;
    countdown = clamp_delay({2'b00, t_slot_low});
  endfunction

  function automatic void start_byte(input logic [7:0] b);
    shreg = b;
    bits_to_go = owbm_pkg::BITS_PER_BYTE;
    start_slot();
  endfunction

  function automatic owbm_pkg::out_item_t predict_status(input owbm_pkg::in_item_t it);
    owbm_pkg::out_item_t r;
    logic                finished;
    logic                expired;
    logic                rbit;
    finished = 1'b0;
    if (it.operation != owbm_pkg::OP_TICK) begin
      if (ph == ST_IDLE) begin
        case (it.operation)
          owbm_pkg::OP_RESET: begin
            stage = owbm_pkg::STAGE_NONE;
            start_reset();
          end
          owbm_pkg::OP_BYTE: begin
            stage = owbm_pkg::STAGE_NONE;
            start_byte(it.data_byte);
          end
          default: begin
            cmd_byte = it.data_byte;
            stage = owbm_pkg::STAGE_RST;
            start_reset();
          end
        endcase
      end
    end else if (ph != ST_IDLE) begin
      if (ph != ST_SLOT_READ) countdown = countdown - 1'b1;
      expired = (countdown == '0);
      case (ph)
        ST_HOLD_LOW: begin
          if (expired) begin
            drive = 1'b0;
            ph = ST_PRESENCE;
            countdown = clamp_delay(t_presence);
          end
        end
        ST_PRESENCE: begin
          if (expired) begin
            err = it.line_level;
            ph = ST_TAIL;
            countdown = clamp_delay(t_tail);
          end
        end
        ST_TAIL: begin
          if (expired) begin
            if (!it.line_level) err = 1'b1;
            if (stage == owbm_pkg::STAGE_RST) begin
              stage = owbm_pkg::STAGE_SKIP;
              start_byte(owbm_pkg::SKIP_ROM_BYTE);
            end else begin
              stage = owbm_pkg::STAGE_NONE;
              ph = ST_IDLE;
              finished = 1'b1;
            end
          end
        end
        ST_SLOT_LOW: begin
          if (expired) begin
            if (shreg[0]) drive = 1'b0;
            ph = ST_SLOT_READ;
          end
        end
        ST_SLOT_READ: begin
          rbit = shreg[0] & it.line_level;
          shreg = {rbit, shreg[7:1]};
          bits_to_go = bits_to_go - 1'b1;
          ph = ST_SLOT_REST;
          countdown = clamp_delay({2'b00, t_slot_end});
        end
        ST_SLOT_REST: begin
          if (expired) begin
            drive = 1'b0;
            if (bits_to_go != 0) begin
              start_slot();
            end else if (stage == owbm_pkg::STAGE_SKIP) begin
              stage = owbm_pkg::STAGE_CMD;
              start_byte(cmd_byte);
            end else if (stage == owbm_pkg::STAGE_CMD) begin
              stage = owbm_pkg::STAGE_NONE;
              ph = ST_IDLE;
              finished = 1'b1;
            end else begin
              rd_byte = shreg;
              stage = owbm_pkg::STAGE_NONE;
              ph = ST_IDLE;
              finished = 1'b1;
            end
          end
        end
        default: begin
          ph = ST_IDLE;
          drive = 1'b0;
          stage = owbm_pkg::STAGE_NONE;
        end
      endcase
    end
    r.drive_low = drive;
    r.busy_res  = (ph != ST_IDLE);
    r.done_res  = finished;
    r.read_byte = rd_byte;
    r.bus_error = err;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s expected %0h got %0h", name, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    owbm_pkg::out_item_t want, got;
    if (rst) begin
      ph = ST_IDLE;
      countdown = '0;
      shreg = '0;
      bits_to_go = '0;
      cmd_byte = '0;
      stage = owbm_pkg::STAGE_NONE;
      err = 1'b0;
      drive = 1'b0;
      rd_byte = '0;
      t_reset_low = 10'd480;
      t_presence = 10'd72;
      t_tail = 10'd428;
      t_slot_low = 8'd2;
      t_slot_end = 8'd45;
      expected_status.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_status.size() == 0) begin
          $error("result transfer with no status expected");
          errs++;
        end else begin
          want = expected_status.pop_front();
          check_field("drive_low", want.drive_low, got.drive_low);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("bus_error", want.bus_error, got.bus_error);
        end
      end
      if (in_ch.valid && in_ch.ready) expected_status.push_back(predict_status(in_ch.payload));
      if (cfg_we) begin
        case (cfg_index)
          owbm_pkg::REG_RESET_LOW:     t_reset_low = cfg_data[9:0];
          owbm_pkg::REG_PRESENCE_WAIT: t_presence = cfg_data[9:0];
          owbm_pkg::REG_RESET_TAIL:    t_tail = cfg_data[9:0];
          owbm_pkg::REG_SLOT_LOW:      t_slot_low = cfg_data[7:0];
          owbm_pkg::REG_SLOT_END:      t_slot_end = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    fails <= errs;
    expected_left <= expected_status.size();
    model_busy <= (ph != ST_IDLE);
  end

endmodule

[tb/sv/one_wire_bus_master_core_test.sv]
// top of the one-wire bus master core test: clock, reset, register writes and item stimulus
// with random source gaps and sink stalls; the verdict comes from owbm_bus_checker
// depends on owbm_pkg, owbm_if.sv, owbm_bus_checker and the core itself
module one_wire_bus_master_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int RANDOM_ITEMS = 60;
  localparam int CALM_AFTER = 30;

  typedef enum int {LINE_RANDOM, LINE_ONE, LINE_ZERO, LINE_MOSTLY_ONE} line_mode_t;

  logic                           clk, rst, cfg_we;
  logic [owbm_pkg::IDX_WIDTH-1:0] cfg_index;
  logic [owbm_pkg::CFG_WIDTH-1:0] cfg_data;
  int                             fails, expected_left;
  logic                           model_busy;
  bit                             src_gaps, stall_on, calm;
  int                             busy_items;

  owbm_in_if  in_ch();
  owbm_out_if out_ch();

  one_wire_bus_master_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  owbm_bus_checker status_check (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .fails(fails),
    .expected_left(expected_left),
    .model_busy(model_busy)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    stall_on = 1'b1;
    forever begin
      repeat ($urandom_range(40, 300)) @(posedge clk);
      stall_on = !stall_on;
    end
  end

  // result sink with bursts of backpressure
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && stall_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic pick_level(input line_mode_t mode);
    case (mode)
      LINE_ONE:        return 1'b1;
      LINE_ZERO:       return 1'b0;
      LINE_MOSTLY_ONE: return $urandom_range(0, 7) != 0;
      default:         return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send(input logic [1:0] op, input logic [7:0] data, input logic lvl);
    owbm_pkg::in_item_t it;
    it.operation = op;
    it.data_byte = data;
    it.line_level = lvl;
    if (src_gaps && !calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  // start one operation and tick until the bus is idle again, with random stray start items mixed in
  task automatic run_op(input logic [1:0] op, input logic [7:0] data, input line_mode_t mode,
                        input int noise_pct);
    logic [1:0] stray_op;
    send(op, data, pick_level(mode));
    busy_items++;
    do begin
      if (noise_pct > 0 && $urandom_range(1, 100) <= noise_pct) begin
        stray_op = 2'($urandom_range(owbm_pkg::OP_RESET, owbm_pkg::OP_CMD));
        send(stray_op, 8'($urandom), pick_level(mode));
      end
      if ($urandom_range(0, 199) == 0) drain();
      send(owbm_pkg::OP_TICK, 8'($urandom), pick_level(mode));
      busy_items++;
    end while (model_busy);
  endtask

  task automatic set_timing(input logic [9:0] low_us, pres_us, tail_us, slot_us, rest_us);
    logic [owbm_pkg::CFG_WIDTH-1:0] vals [1 << owbm_pkg::IDX_WIDTH];
    foreach (vals[i]) vals[i] = owbm_pkg::CFG_WIDTH'($urandom);
    vals[owbm_pkg::REG_RESET_LOW] = low_us;
    vals[owbm_pkg::REG_PRESENCE_WAIT] = pres_us;
    vals[owbm_pkg::REG_RESET_TAIL] = tail_us;
    vals[owbm_pkg::REG_SLOT_LOW] = slot_us;
    vals[owbm_pkg::REG_SLOT_END] = rest_us;
    drain();
    repeat (2) @(posedge clk);
    for (int i = 0; i < (1 << owbm_pkg::IDX_WIDTH); i++) begin
      cfg_we <= 1'b1;
      cfg_index <= owbm_pkg::IDX_WIDTH'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [9:0] short_delay();
    return 10'($urandom_range(0, 4));
  endfunction

  function automatic logic [9:0] short_slot();
    return short_delay() | (($urandom_range(0, 7) == 0) ? 10'h300 : 10'h000);
  endfunction

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    src_gaps = 1'b1;
    calm = 1'b0;
    busy_items = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset timing values
    send(owbm_pkg::OP_TICK, 8'h00, 1'b0);
    send(owbm_pkg::OP_TICK, 8'hFF, 1'b1);
    run_op(owbm_pkg::OP_BYTE, 8'h96, LINE_RANDOM, 0);

    set_timing(10'd3, 10'd2, 10'd2, 10'd1, 10'd1);
    run_op(owbm_pkg::OP_RESET, 8'h00, LINE_ONE, 0);
    run_op(owbm_pkg::OP_RESET, 8'h00, LINE_ZERO, 0);
    run_op(owbm_pkg::OP_BYTE, 8'hFF, LINE_ONE, 0);
    run_op(owbm_pkg::OP_BYTE, 8'hA5, LINE_ZERO, 0);
    run_op(owbm_pkg::OP_CMD, 8'h5A, LINE_MOSTLY_ONE, 30);

    // zero delays count as one microsecond
    set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    run_op(owbm_pkg::OP_RESET, 8'h00, LINE_RANDOM, 0);
    run_op(owbm_pkg::OP_BYTE, 8'h69, LINE_RANDOM, 0);
    run_op(owbm_pkg::OP_CMD, 8'hC3, LINE_MOSTLY_ONE, 0);

    busy_items = 0;
    while (busy_items < RANDOM_ITEMS) begin
      set_timing(short_delay(), short_delay(), short_delay(), short_slot(), short_slot());
      repeat ($urandom_range(1, 2)) begin
        if (busy_items >= CALM_AFTER) calm = 1'b1;
        src_gaps = $urandom_range(0, 2) != 0;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send(owbm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
        end
        run_op(2'($urandom_range(owbm_pkg::OP_RESET, owbm_pkg::OP_CMD)), 8'($urandom),
               line_mode_t'($urandom_range(0, 3)), ($urandom_range(0, 1) == 0) ? 0 : 5);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
